// File: design/lmb_pkg.sv
// Shared types and constants for the local mean binarizer.
package lmb_pkg;

  localparam int INT_W      = 10;
  localparam int MAX_INT    = 3 * 255;
  localparam int MAX_HEIGHT = 4096;
  localparam int HT_W       = 13;
  localparam int ROW_W      = 13;
  localparam int YW         = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int GROUP      = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2
  } cfg_reg_t;

endpackage

// File: design/local_mean_binarizer.sv
// Streaming adaptive-threshold binarizer over a clipped square local-mean window.
//
// Takes one item per clock while s_tready is high: each item in the frame writes its pixel
// intensity into the line store, updates one column sum (read, add the new row,
// drop the row leaving the window, write back) and slides a row of column sums
// that feeds a registered adder tree. A result passes the stage registers and the
// output queue before it is offered on the output; the result for raster
// position o is released by item o + radius*width + radius, so the host sends that
// many flush items after a frame. s_tready drops only when the 8-entry output
// queue plus the results in flight would fill it. The memories need no
// initialization after reset: every entry read inside a frame was written earlier
// in that frame.
module local_mean_binarizer
  import lmb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // white[0], zero fill
  output logic                  m_tlast,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int NT         = 2 * MAX_RADIUS + 1;
  localparam int RING_DEPTH = NT * MAX_WIDTH;
  localparam int RA_W       = $clog2(RING_DEPTH);
  localparam int OFF_W      = $clog2(RING_DEPTH + 1);
  localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CS_W       = $clog2(NT * MAX_INT + 1);
  localparam int WS_W       = $clog2(NT * NT * MAX_INT + 1);
  localparam int CNT_W      = $clog2(NT * NT + 1);
  localparam int SPAN_W     = $clog2(NT + 1);
  localparam int CMP_W      = COL_W + 2;
  localparam int YC_W       = HT_W + 1;
  localparam int PR_W       = INT_W + CNT_W;
  localparam int NG         = (NT + GROUP - 1) / GROUP;

  // configuration
  logic [WID_W-1:0] cfg_width;
  logic [HT_W-1:0]  cfg_height;
  logic [RAD_W-1:0] cfg_radius;

  // input side position state
  logic             fresh;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_x;
  logic [YW-1:0]    out_y;
  logic [LAG_W-1:0] lag_left;
  logic [RA_W-1:0]  wr_ptr;
  logic [RA_W-1:0]  sub_ptr;
  logic [RA_W-1:0]  own_ptr;

  // stage 1
  logic             s1_valid;
  logic             s1_out;
  logic [COL_W-1:0] s1_col;
  logic             s1_first;
  logic             s1_add;
  logic             s1_sub;
  logic [INT_W-1:0] s1_int;
  logic [COL_W-1:0] s1_x;
  logic [YW-1:0]    s1_y;
  logic             s1_done;
  logic             s1_lag0;
  logic             s1_fwd;
  logic [CS_W-1:0]  s1_fwd_val;

  // stage 2
  logic              s2_out;
  logic [COL_W-1:0]  s2_x;
  logic              s2_done;
  logic [INT_W-1:0]  s2_own;
  logic [SPAN_W-1:0] s2_rows;
  logic [SPAN_W-1:0] s2_cols;

  // stage 3
  logic             s3_out;
  logic             s3_done;
  logic [INT_W-1:0] s3_own;
  logic [CNT_W-1:0] s3_cnt;
  logic [CS_W-1:0]  s3_masked [NT];

  // stage 4
  logic            s4_out;
  logic            s4_done;
  logic [PR_W-1:0] s4_prod;
  logic [WS_W-1:0] s4_grp [NG];

  logic [CS_W-1:0] taps [NT];

  // output queue
  logic                fifo_white [FIFO_DEPTH];
  logic                fifo_done  [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  fifo_wptr;
  logic [FIFO_AW-1:0]  fifo_rptr;
  logic [FIFO_CW-1:0]  fifo_count;

  // combinational
  logic              accept;
  logic              cfg_hit;
  logic [LAG_W-1:0]  lag;
  logic [OFF_W-1:0]  sub_off;
  logic [RA_W-1:0]   init_sub;
  logic [RA_W-1:0]   init_own;
  logic [RA_W-1:0]   wr_cur;
  logic [RA_W-1:0]   sub_cur;
  logic [RA_W-1:0]   own_cur;
  logic [LAG_W-1:0]  lag_cur;
  logic              out_en;
  logic              add_en;
  logic              sub_en;
  logic              done;
  logic [INT_W-1:0]  pix_int;
  logic [INT_W-1:0]  sub_q;
  logic [INT_W-1:0]  own_q;
  logic [CS_W-1:0]   cs_q;
  logic [CS_W-1:0]   cs_old;
  logic [CS_W-1:0]   cs_new;
  logic [INT_W-1:0]  s1_own;
  logic [SPAN_W-1:0] rows;
  logic [SPAN_W-1:0] cols;
  logic [CS_W-1:0]   masked [NT];
  logic [WS_W-1:0]   grp [NG];
  logic [WS_W-1:0]   win_sum;
  logic              white;
  logic              push;
  logic              pop;
  logic [FIFO_CW-1:0] inflight;

  function automatic logic [RA_W-1:0] ring_inc(input logic [RA_W-1:0] a);
    logic [RA_W-1:0] r;
    r = (a == RA_W'(RING_DEPTH - 1)) ? '0 : a + RA_W'(1);
    return r;
  endfunction

  assign accept  = s_tvalid && s_tready;
  assign cfg_hit = cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                   cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_WINDOW_RADIUS);

  assign lag      = LAG_W'(cfg_radius) * LAG_W'(cfg_width) + LAG_W'(cfg_radius);
  assign sub_off  = OFF_W'({cfg_radius, 1'b1}) * OFF_W'(cfg_width);
  assign init_sub = RA_W'(OFF_W'(RING_DEPTH) - sub_off);
  assign init_own = (lag == '0) ? '0 : RA_W'(OFF_W'(RING_DEPTH) - OFF_W'(lag));

  assign wr_cur  = fresh ? '0 : wr_ptr;
  assign sub_cur = fresh ? init_sub : sub_ptr;
  assign own_cur = fresh ? init_own : own_ptr;
  assign lag_cur = fresh ? lag : lag_left;
  assign out_en  = (lag_cur == '0);
  assign add_en  = in_row < ROW_W'(cfg_height);
  assign sub_en  = in_row >= ROW_W'({cfg_radius, 1'b1});
  assign done    = out_en && (out_y == YW'(cfg_height - HT_W'(1)))
                   && (out_x == COL_W'(cfg_width - WID_W'(1)));
  assign pix_int = s_tuser ? '0
                   : INT_W'(s_tdata[7:0]) + INT_W'(s_tdata[15:8]) + INT_W'(s_tdata[23:16]);

  lmb_ram #(.WIDTH(INT_W), .DEPTH(RING_DEPTH)) u_ring_sub (
    .clk(clk), .we(accept && add_en), .waddr(wr_cur), .wdata(pix_int),
    .raddr(sub_cur), .rdata(sub_q)
  );

  lmb_ram #(.WIDTH(INT_W), .DEPTH(RING_DEPTH)) u_ring_own (
    .clk(clk), .we(accept && add_en), .waddr(wr_cur), .wdata(pix_int),
    .raddr(own_cur), .rdata(own_q)
  );

  lmb_ram #(.WIDTH(CS_W), .DEPTH(MAX_WIDTH)) u_colsum (
    .clk(clk), .we(s1_valid), .waddr(s1_col), .wdata(cs_new),
    .raddr(in_col), .rdata(cs_q)
  );

  // stage 1: column sum update and window extent
  always_comb begin
    logic [YC_W-1:0]  y0;
    logic [YC_W-1:0]  y1;
    logic [CMP_W-1:0] x0;
    logic [CMP_W-1:0] x1;
    cs_old = s1_first ? '0 : (s1_fwd ? s1_fwd_val : cs_q);
    cs_new = cs_old + (s1_add ? CS_W'(s1_int) : '0) - (s1_sub ? CS_W'(sub_q) : '0);
    s1_own = s1_lag0 ? s1_int : own_q;
    y0 = (YC_W'(s1_y) >= YC_W'(cfg_radius)) ? YC_W'(s1_y) - YC_W'(cfg_radius) : '0;
    y1 = (YC_W'(s1_y) + YC_W'(cfg_radius) < YC_W'(cfg_height))
         ? YC_W'(s1_y) + YC_W'(cfg_radius) : YC_W'(cfg_height) - YC_W'(1);
    x0 = (CMP_W'(s1_x) >= CMP_W'(cfg_radius)) ? CMP_W'(s1_x) - CMP_W'(cfg_radius) : '0;
    x1 = (CMP_W'(s1_x) + CMP_W'(cfg_radius) < CMP_W'(cfg_width))
         ? CMP_W'(s1_x) + CMP_W'(cfg_radius) : CMP_W'(cfg_width) - CMP_W'(1);
    rows = SPAN_W'(y1 - y0 + YC_W'(1));
    cols = SPAN_W'(x1 - x0 + CMP_W'(1));
  end

  // stage 2: keep the taps of the same row that fall inside the window
  always_comb begin
    logic [CMP_W-1:0] xr;
    xr = CMP_W'(s2_x) + CMP_W'(cfg_radius);
    for (int d = 0; d < NT; d++) begin
      masked[d] = (CMP_W'(d) <= CMP_W'({cfg_radius, 1'b0}) && CMP_W'(d) <= xr
                   && xr < CMP_W'(d) + CMP_W'(cfg_width)) ? taps[d] : '0;
    end
  end

  // stage 3: partial sums
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp[g] = '0;
      for (int e = 0; e < GROUP; e++) begin
        if (g * GROUP + e < NT) begin
          grp[g] = grp[g] + WS_W'(s3_masked[g * GROUP + e]);
        end
      end
    end
  end

  // stage 4: final sum and threshold
  always_comb begin
    win_sum = '0;
    for (int g = 0; g < NG; g++) begin
      win_sum = win_sum + s4_grp[g];
    end
    white = s4_prod > PR_W'(win_sum);
  end

  assign push     = s4_out;
  assign pop      = m_tvalid && m_tready;
  assign inflight = FIFO_CW'(s1_out) + FIFO_CW'(s2_out) + FIFO_CW'(s3_out) + FIFO_CW'(s4_out);
  assign s_tready = (fifo_count + inflight) < FIFO_CW'(FIFO_DEPTH);
  assign m_tvalid = (fifo_count != '0);
  assign m_tdata  = {7'd0, fifo_white[fifo_rptr]};
  assign m_tlast  = fifo_done[fifo_rptr];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WID_W'(1);
      cfg_height <= HT_W'(1);
      cfg_radius <= RAD_W'(1);
      fresh      <= 1'b1;
      in_col     <= '0;
      in_row     <= '0;
      out_x      <= '0;
      out_y      <= '0;
      lag_left   <= '0;
      wr_ptr     <= '0;
      sub_ptr    <= '0;
      own_ptr    <= '0;
      s1_valid   <= 1'b0;
      s1_out     <= 1'b0;
      s2_out     <= 1'b0;
      s3_out     <= 1'b0;
      s4_out     <= 1'b0;
      fifo_wptr  <= '0;
      fifo_rptr  <= '0;
      fifo_count <= '0;
    end else begin
      s1_valid <= accept;
      s1_out   <= accept && out_en;
      s2_out   <= s1_out;
      s3_out   <= s2_out;
      s4_out   <= s3_out;

      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            if (cfg_data[10:0] == '0) begin
              cfg_width <= WID_W'(1);
            end else if (int'(cfg_data[10:0]) > MAX_WIDTH) begin
              cfg_width <= WID_W'(MAX_WIDTH);
            end else begin
              cfg_width <= WID_W'(cfg_data[10:0]);
            end
          end
          REG_FRAME_HEIGHT: begin
            if (cfg_data == '0) begin
              cfg_height <= HT_W'(1);
            end else if (int'(cfg_data) > MAX_HEIGHT) begin
              cfg_height <= HT_W'(MAX_HEIGHT);
            end else begin
              cfg_height <= cfg_data;
            end
          end
          REG_WINDOW_RADIUS: begin
            if (int'(cfg_data[3:0]) > MAX_RADIUS) begin
              cfg_radius <= RAD_W'(MAX_RADIUS);
            end else begin
              cfg_radius <= RAD_W'(cfg_data[3:0]);
            end
          end
          default: begin
          end
        endcase
      end

      if (cfg_hit || (accept && done)) begin
        fresh  <= 1'b1;
        in_col <= '0;
        in_row <= '0;
        out_x  <= '0;
        out_y  <= '0;
      end else if (accept) begin
        fresh    <= 1'b0;
        wr_ptr   <= ring_inc(wr_cur);
        sub_ptr  <= ring_inc(sub_cur);
        own_ptr  <= ring_inc(own_cur);
        lag_left <= out_en ? '0 : lag_cur - LAG_W'(1);
        if (in_col == COL_W'(cfg_width - WID_W'(1))) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (out_en) begin
          if (out_x == COL_W'(cfg_width - WID_W'(1))) begin
            out_x <= '0;
            out_y <= out_y + YW'(1);
          end else begin
            out_x <= out_x + COL_W'(1);
          end
        end
      end

      if (push) begin
        fifo_wptr <= fifo_wptr + FIFO_AW'(1);
      end
      if (pop) begin
        fifo_rptr <= fifo_rptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s1_col     <= in_col;
    s1_first   <= (in_row == '0);
    s1_add     <= add_en;
    s1_sub     <= sub_en;
    s1_int     <= pix_int;
    s1_x       <= out_x;
    s1_y       <= out_y;
    s1_done    <= done;
    s1_lag0    <= (lag == '0);
    s1_fwd     <= s1_valid && (s1_col == in_col);
    s1_fwd_val <= cs_new;

    if (s1_valid) begin
      taps[0] <= cs_new;
      for (int d = 1; d < NT; d++) begin
        taps[d] <= taps[d-1];
      end
    end

    s2_x    <= s1_x;
    s2_done <= s1_done;
    s2_own  <= s1_own;
    s2_rows <= rows;
    s2_cols <= cols;

    s3_done <= s2_done;
    s3_own  <= s2_own;
    s3_cnt  <= CNT_W'(CNT_W'(s2_rows) * CNT_W'(s2_cols));
    for (int d = 0; d < NT; d++) begin
      s3_masked[d] <= masked[d];
    end

    s4_done <= s3_done;
    s4_prod <= PR_W'(s3_own) * PR_W'(s3_cnt);
    for (int g = 0; g < NG; g++) begin
      s4_grp[g] <= grp[g];
    end

    if (push) begin
      fifo_white[fifo_wptr] <= white;
      fifo_done[fifo_wptr]  <= s4_done;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("output queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (fifo_count + inflight) <= FIFO_CW'(FIFO_DEPTH))
    else $error("results in flight exceed queue room");

  assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> fresh && in_col == '0 && in_row == '0)
    else $error("frame end did not restart positions");

endmodule

// File: design/lmb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
